[sv/fhfdc_pkg.sv]
package fhfdc_pkg;

  localparam int unsigned HdrBytes        = 20;
  localparam logic [1:0]  HdrVersionOk    = 2'd2;
  localparam logic [3:0]  HdrTypeData     = 4'd10;
  localparam logic [7:0]  MaxPayloadReset = 8'd200;

  typedef enum logic [2:0] {
    VERDICT_RAW        = 3'd0,
    VERDICT_PAYLOAD    = 3'd1,
    VERDICT_WRONG_TYPE = 3'd2,
    VERDICT_DUPLICATE  = 3'd3,
    VERDICT_EMPTY      = 3'd4
  } verdict_e;

  // Front-end classification of one frame.
  typedef enum logic [1:0] {
    KIND_EMPTY      = 2'd0,
    KIND_WRONG_TYPE = 2'd1,
    KIND_RAW        = 2'd2,
    KIND_PARSED     = 2'd3
  } kind_e;

  // One queued work item. len is the frame length for raw frames and the
  // header size for parsed ones.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  len;
    logic [15:0] magic;
    logic [47:0] source;
  } item_t;

endpackage

[sv/fhfdc_front.sv]
module fhfdc_front
  import fhfdc_pkg::*;
(
  input  logic        start_i,
  input  logic        full_i,
  input  logic [7:0]  frame_length_i,
  input  logic [3:0]  hdr_type_i,
  input  logic [1:0]  hdr_version_i,
  input  logic [7:0]  hdr_size_i,
  input  logic [15:0] frame_magic_i,
  input  logic [47:0] source_address_i,
  output logic        push_o,
  output item_t       item_o
);

  logic [8:0] total_len;
  logic       parse_ok;

  assign total_len = 9'(HdrBytes) + {1'b0, hdr_size_i};
  assign parse_ok  = ({1'b0, frame_length_i} >= 9'(HdrBytes)) &&
                     (hdr_version_i == HdrVersionOk) &&
                     (total_len == {1'b0, frame_length_i});

  assign push_o = start_i && !full_i;

  always_comb begin
    item_o.magic  = frame_magic_i;
    item_o.source = source_address_i;
    item_o.len    = frame_length_i;
    if (frame_length_i == 8'd0) begin
      item_o.kind = KIND_EMPTY;
    end else if (parse_ok && (hdr_type_i != HdrTypeData)) begin
      item_o.kind = KIND_WRONG_TYPE;
    end else if (parse_ok) begin
      item_o.kind = KIND_PARSED;
      item_o.len  = hdr_size_i;
    end else begin
      item_o.kind = KIND_RAW;
    end
  end

endmodule

[sv/fhfdc_fifo.sv]
module fhfdc_fifo
  import fhfdc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t pop_data_o,
  output logic  empty_o
);

  // Two entries: one being handed to the back end, one waiting.
  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/fhfdc_back.sv]
module fhfdc_back
  import fhfdc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  item_t      head_i,
  output logic       pop_o,
  input  logic [7:0] max_payload_i,
  output logic       done_o,
  output logic [2:0] verdict_o,
  output logic [4:0] payload_offset_o,
  output logic [7:0] deliver_length_o
);

  localparam int unsigned PtrW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_RESOLVE = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Cache entries; the type is always the data type when stored, so only
  // magic and source are kept.
  logic [CACHE_ENTRIES-1:0] valid_q;
  logic [15:0]              magic_q  [CACHE_ENTRIES];
  logic [47:0]              source_q [CACHE_ENTRIES];
  logic [PtrW-1:0]          ptr_q, ptr_d;

  item_t                    work_q;
  logic [CACHE_ENTRIES-1:0] match_q, match_d;

  logic       hit;
  logic       insert;
  verdict_e   res_verdict;
  logic [4:0] res_offset;
  logic [7:0] res_len;
  logic [7:0] clamped;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    for (int unsigned i = 0; i < CACHE_ENTRIES; i++) begin
      match_d[i] = valid_q[i] && (head_i.magic != 16'd0) &&
                   (magic_q[i] == head_i.magic) && (source_q[i] == head_i.source);
    end
  end

  assign hit     = |match_q;
  assign insert  = (state_q == ST_RESOLVE) && (work_q.kind == KIND_PARSED) &&
                   !hit && (work_q.magic != 16'd0);
  assign clamped = (work_q.len > max_payload_i) ? max_payload_i : work_q.len;

  always_comb begin
    res_verdict = VERDICT_EMPTY;
    res_offset  = 5'd0;
    res_len     = 8'd0;
    case (work_q.kind)
      KIND_WRONG_TYPE: res_verdict = VERDICT_WRONG_TYPE;
      KIND_PARSED: begin
        if (hit) begin
          res_verdict = VERDICT_DUPLICATE;
        end else if (work_q.len != 8'd0) begin
          res_verdict = VERDICT_PAYLOAD;
          res_offset  = 5'(HdrBytes);
          res_len     = clamped;
        end
      end
      KIND_RAW: begin
        res_verdict = VERDICT_RAW;
        res_len     = clamped;
      end
      default: res_verdict = VERDICT_EMPTY;
    endcase
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        state_d = ST_IDLE;
        if (insert) begin
          ptr_d = (ptr_q == PtrW'(CACHE_ENTRIES - 1)) ? '0 : ptr_q + PtrW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      valid_q <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      done_o  <= state_q == ST_RESOLVE;
      if (insert) begin
        valid_q[ptr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q  <= head_i;
      match_q <= match_d;
    end
    if (insert) begin
      magic_q[ptr_q]  <= work_q.magic;
      source_q[ptr_q] <= work_q.source;
    end
    if (state_q == ST_RESOLVE) begin
      verdict_o        <= res_verdict;
      payload_offset_o <= res_offset;
      deliver_length_o <= res_len;
    end
  end

endmodule

[sv/frame_header_filter_dedup_cache_core.sv]
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-----------------------------------
// frame     | in        | start & !busy             | frame_length_i, hdr_*_i,
//           |           |                           | frame_magic_i, source_address_i
// verdict   | out       | done_o, one-cycle strobe  | verdict_o, payload_offset_o,
//           |           |                           | deliver_length_o
// config    | in        | cfg_valid_i & cfg_ready_o | cfg_data_i (max_payload)
//
// Front end classifies each frame in the accept cycle and pushes it into a two-entry queue.
// Back end handles each frame in ST_IDLE then ST_RESOLVE: pop and compare against all cache
// entries, then resolve and update the cache; done_o strobes the cycle after ST_RESOLVE.
// Frames are accepted while the back end works on an earlier one. busy is high only while
// the queue is full. The receiver cannot stall. Reset clears the cache valid bits and the
// round-robin pointer and sets max_payload to 200; cache contents need no clearing.
module frame_header_filter_dedup_cache_core
  import fhfdc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // frame transactions
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  frame_length_i,
  input  logic [3:0]  hdr_type_i,
  input  logic [1:0]  hdr_version_i,
  input  logic [7:0]  hdr_size_i,
  input  logic [15:0] frame_magic_i,
  input  logic [47:0] source_address_i,
  // verdict transactions
  output logic        done_o,
  output logic [2:0]  verdict_o,
  output logic [4:0]  payload_offset_o,
  output logic [7:0]  deliver_length_o,
  // config transactions
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic       full;
  logic       empty;
  logic       push;
  logic       pop;
  item_t      front_item;
  item_t      head_item;
  logic [7:0] max_payload_q;

  // Config is only to be written while idle; the block itself does not enforce this, so always ready.
  assign cfg_ready_o = 1'b1;
  assign busy        = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_payload_q <= cfg_data_i;
    end
  end

  fhfdc_front u_front (
    .start_i          (start),
    .full_i           (full),
    .frame_length_i   (frame_length_i),
    .hdr_type_i       (hdr_type_i),
    .hdr_version_i    (hdr_version_i),
    .hdr_size_i       (hdr_size_i),
    .frame_magic_i    (frame_magic_i),
    .source_address_i (source_address_i),
    .push_o           (push),
    .item_o           (front_item)
  );

  fhfdc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head_item),
    .empty_o     (empty)
  );

  fhfdc_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .head_i           (head_item),
    .pop_o            (pop),
    .max_payload_i    (max_payload_q),
    .done_o           (done_o),
    .verdict_o        (verdict_o),
    .payload_offset_o (payload_offset_o),
    .deliver_length_o (deliver_length_o)
  );

endmodule
